FILE: src/arp_cache_and_responder_core_macros.svh
// Assertion macros shared by the ARP cache checker.
`ifndef ARP_CACHE_AND_RESPONDER_CORE_MACROS_SVH
`define ARP_CACHE_AND_RESPONDER_CORE_MACROS_SVH

// Assert a property on every clock edge outside reset.
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert that a trigger is followed by a consequence in the next cycle.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/arpc_pkg.sv
// Types, constants and codes of the ARP cache and responder.
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;

  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_PRS = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_SHORT       = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE    = 3'd1;
  localparam logic [2:0] ST_LEARNED     = 3'd2;
  localparam logic [2:0] ST_LEARN_REPLY = 3'd3;
  localparam logic [2:0] ST_HIT         = 3'd4;
  localparam logic [2:0] ST_MISS_REQ    = 3'd5;
  localparam logic [2:0] ST_NO_DEVICE   = 3'd6;

  // Item kinds
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // Frame field values
  localparam logic [15:0] ARP_MIN_LEN = 16'd28;
  localparam logic [15:0] HTYPE_ETH   = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQ      = 16'd1;
  localparam logic [1:0]  TX_OP_REQ   = 2'd1;
  localparam logic [1:0]  TX_OP_REP   = 2'd2;
  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [15:0]      payload_len;
    logic [15:0]      hw_type;
    logic [15:0]      proto_type;
    logic [15:0]      operation;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  src_ip;
    logic [IP_W-1:0]  dst_ip;
    logic [IP_W-1:0]  query_ip;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             send_frame;
    logic [MAC_W-1:0] dest_mac;
    logic [1:0]       tx_operation;
    logic [MAC_W-1:0] tx_target_mac;
    logic [IP_W-1:0]  tx_target_ip;
    logic [MAC_W-1:0] resolved_mac;
  } out_word_t;

  // One cache line as stored in the memory
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

FILE: src/arp_cache_and_responder_core.sv
// ARP cache and responder: top level with scan control and result register.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per item,
// either a received ARP frame (kind 0) or a resolve request (kind 1).
// Output channel (out_valid_o / out_stall_i / out_word_o): exactly one
// result word per item, in item order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 own IP, 1 own MAC, 2 device present); other indexes are ignored.
// Items are handled one at a time. A frame that is short or has wrong types,
// or a resolve with no device, skips the scan and goes straight to done.
// Other items scan the cache memory one line per cycle, lowest index first,
// stopping at the first hit or after the last line; the next item is taken
// once the result has been handed to the output register.
// The scan reads through the registered read port of the cache memory.
// A learn writes back in the cycle the scan ends.
// Reset clears the valid marks, the replacement pointer and the control and
// configuration registers, not the memory content or the payload registers.
// A finished result waits in the output register while the receiver stalls;
// a new item is accepted meanwhile and held until the output register is free.
module arp_cache_and_responder_core #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  arpc_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output arpc_pkg::out_word_t                out_word_o,
  input  logic                               cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam int ENTRY_W = $bits(arpc_pkg::entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [arpc_pkg::IP_W-1:0]  own_ip_q;
  logic [arpc_pkg::MAC_W-1:0] own_mac_q;
  logic                       dev_prs_q;

  arpc_pkg::in_word_t  item_q, item_d;
  arpc_pkg::out_word_t res_q, res_d;
  arpc_pkg::out_word_t out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [arpc_pkg::IP_W-1:0] key_q, key_d;

  logic [IDX_W-1:0]          scan_q, scan_d;
  logic                      issue_q, issue_d;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic [CACHE_ENTRIES-1:0]  valid_q, valid_d;
  logic [IDX_W-1:0]          slot_q, slot_d;

  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  arpc_pkg::entry_t   mem_wdata, rd_entry;
  logic [ENTRY_W-1:0] mem_rdata;

  logic match, end_miss, reply;

  arpc_mem #(
    .DEPTH (CACHE_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_q),
    .rdata_o (mem_rdata)
  );

  assign rd_entry = arpc_pkg::entry_t'(mem_rdata);

  // Compare the line that came back against the key
  assign match    = rd_vld_q && valid_q[rd_idx_q] && (rd_entry.ip == key_q);
  assign end_miss = rd_vld_q && (rd_idx_q == LAST_IDX) && !match;
  assign reply    = (item_q.operation == arpc_pkg::OP_REQ) &&
                    (item_q.dst_ip == own_ip_q);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
      dev_prs_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arpc_pkg::CFG_OWN_IP:  own_ip_q  <= cfg_wdata_i[arpc_pkg::IP_W-1:0];
        arpc_pkg::CFG_OWN_MAC: own_mac_q <= cfg_wdata_i;
        arpc_pkg::CFG_DEV_PRS: dev_prs_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequence one item: check, scan, write back, hand over the result
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    key_d       = key_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    scan_d      = scan_q;
    issue_d     = issue_q;
    valid_d     = valid_q;
    slot_d      = slot_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = rd_idx_q;
    mem_wdata   = '0;

    // Drop the result word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          res_d   = '0;
          scan_d  = '0;
          issue_d = 1'b1;
          state_d = S_SCAN;
          if (in_word_i.kind == arpc_pkg::KIND_FRAME) begin
            key_d = in_word_i.src_ip;
            if (in_word_i.payload_len < arpc_pkg::ARP_MIN_LEN) begin
              res_d.status = arpc_pkg::ST_SHORT;
              issue_d      = 1'b0;
              state_d      = S_DONE;
            end else if (in_word_i.hw_type != arpc_pkg::HTYPE_ETH ||
                         in_word_i.proto_type != arpc_pkg::PTYPE_IPV4) begin
              res_d.status = arpc_pkg::ST_BAD_TYPE;
              issue_d      = 1'b0;
              state_d      = S_DONE;
            end
          end else begin
            key_d = in_word_i.query_ip;
            if (!dev_prs_q) begin
              res_d.status = arpc_pkg::ST_NO_DEVICE;
              issue_d      = 1'b0;
              state_d      = S_DONE;
            end
          end
        end
      end

      S_SCAN: begin
        // Issue the next read
        mem_re = issue_q;
        if (issue_q) begin
          if (scan_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
        // Finish on first hit or after the last line
        if (match || end_miss) begin
          issue_d = 1'b0;
          state_d = S_DONE;
          if (item_q.kind == arpc_pkg::KIND_FRAME) begin
            mem_we        = 1'b1;
            mem_wdata.ip  = item_q.src_ip;
            mem_wdata.mac = item_q.sender_mac;
            if (!match) begin
              mem_waddr        = slot_q;
              valid_d[slot_q]  = 1'b1;
              slot_d           = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
            end
            if (reply) begin
              res_d.status        = arpc_pkg::ST_LEARN_REPLY;
              res_d.send_frame    = 1'b1;
              res_d.dest_mac      = item_q.sender_mac;
              res_d.tx_operation  = arpc_pkg::TX_OP_REP;
              res_d.tx_target_mac = item_q.sender_mac;
              res_d.tx_target_ip  = item_q.src_ip;
            end else begin
              res_d.status = arpc_pkg::ST_LEARNED;
            end
          end else if (match) begin
            res_d.status       = arpc_pkg::ST_HIT;
            res_d.resolved_mac = rd_entry.mac;
          end else begin
            res_d.status       = arpc_pkg::ST_MISS_REQ;
            res_d.send_frame   = 1'b1;
            res_d.dest_mac     = arpc_pkg::BCAST_MAC;
            res_d.tx_operation = arpc_pkg::TX_OP_REQ;
            res_d.tx_target_ip = item_q.query_ip;
          end
        end
      end

      S_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      issue_q     <= 1'b0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      valid_q     <= '0;
      slot_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      issue_q     <= issue_d;
      scan_q      <= scan_d;
      rd_vld_q    <= mem_re;
      rd_idx_q    <= scan_q;
      valid_q     <= valid_d;
      slot_q      <= slot_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    key_q  <= key_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: src/arpc_mem.sv
// Cache line memory: one write port, one read port with registered data.
module arpc_mem #(
  parameter int DEPTH = arpc_pkg::CACHE_ENTRIES,
  parameter int WIDTH = $bits(arpc_pkg::entry_t)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one line
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one line into the registered data output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/arpc_checker.sv
// Port-level checks of the ARP cache and responder, bound to the top level.
`include "arp_cache_and_responder_core_macros.svh"

module arpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input arpc_pkg::out_word_t out_word_o
);

  // A stalled result word holds
  `ARPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "result word changed under stall")

  // One item at a time: an accepted word closes the input
  `ARPC_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input open right after an accept")

  // A frame is sent exactly for a reply or a miss request
  `ARPC_ASSERT(a_send_status, clk_i, rst_ni, out_valid_o |-> (out_word_o.send_frame == (out_word_o.status == arpc_pkg::ST_LEARN_REPLY || out_word_o.status == arpc_pkg::ST_MISS_REQ)), "send flag disagrees with status")

  // Resolved MAC is zero unless the status is a hit
  `ARPC_ASSERT(a_resolved_zero, clk_i, rst_ni, (out_valid_o && out_word_o.status != arpc_pkg::ST_HIT) |-> (out_word_o.resolved_mac == '0), "resolved MAC set without a hit")

  // Frame fields are zero when no frame is sent
  `ARPC_ASSERT(a_no_frame_zero, clk_i, rst_ni, (out_valid_o && !out_word_o.send_frame) |-> (out_word_o.tx_operation == '0 && out_word_o.dest_mac == '0 && out_word_o.tx_target_ip == '0), "frame fields set with no frame")

endmodule

bind arp_cache_and_responder_core arpc_checker u_arpc_checker (.*);

FILE: tb/arp_cache_checker.sv
// Checker for the ARP cache and responder: tracks cache and registers, compares result words.
`timescale 1ns / 1ps

module arp_cache_checker
  import arpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    words_pending_o
);

  localparam int PRINT_LIMIT = 40;

  // Register copies
  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;
  logic             dev_present_q;

  // Cache copy: valid marks, contents and the round-robin victim
  logic [IP_W-1:0]  cache_ip    [CACHE_ENTRIES];
  logic [MAC_W-1:0] cache_mac   [CACHE_ENTRIES];
  logic             cache_valid [CACHE_ENTRIES];
  int               next_victim;

  out_word_t expected_results[$];

  // Print one line per mismatch (up to a limit) and count it
  task automatic report_mismatch(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= PRINT_LIMIT)
      $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", what, got, want));
  endtask

  // Lowest valid line holding this IP, or -1
  function automatic int find_line(input logic [IP_W-1:0] ip);
    int i;
    for (i = 0; i < CACHE_ENTRIES; i++)
      if (cache_valid[i] && cache_ip[i] == ip) return i;
    return -1;
  endfunction

  // Update a matching line in place, else overwrite the victim and advance it
  function automatic void learn_sender(input logic [IP_W-1:0] ip,
                                       input logic [MAC_W-1:0] mac);
    int line;
    line = find_line(ip);
    if (line < 0) begin
      line = next_victim;
      next_victim = (next_victim + 1) % CACHE_ENTRIES;
      cache_ip[line] = ip;
      cache_valid[line] = 1'b1;
    end
    cache_mac[line] = mac;
  endfunction

  // Outcome of one item; updates the cache copy on a learn
  function automatic out_word_t arp_outcome(input in_word_t w);
    out_word_t r;
    int line;
    r = '0;
    if (w.kind == KIND_FRAME) begin
      if (w.payload_len < ARP_MIN_LEN) begin
        r.status = ST_SHORT;
      end else if (w.hw_type != HTYPE_ETH || w.proto_type != PTYPE_IPV4) begin
        r.status = ST_BAD_TYPE;
      end else begin
        learn_sender(w.src_ip, w.sender_mac);
        r.status = ST_LEARNED;
        if (w.operation == OP_REQ && w.dst_ip == own_ip_q) begin
          r.status        = ST_LEARN_REPLY;
          r.send_frame    = 1'b1;
          r.dest_mac      = w.sender_mac;
          r.tx_operation  = TX_OP_REP;
          r.tx_target_mac = w.sender_mac;
          r.tx_target_ip  = w.src_ip;
        end
      end
    end else if (!dev_present_q) begin
      r.status = ST_NO_DEVICE;
    end else begin
      line = find_line(w.query_ip);
      if (line >= 0) begin
        r.status       = ST_HIT;
        r.resolved_mac = cache_mac[line];
      end else begin
        r.status       = ST_MISS_REQ;
        r.send_frame   = 1'b1;
        r.dest_mac     = BCAST_MAC;
        r.tx_operation = TX_OP_REQ;
        r.tx_target_ip = w.query_ip;
      end
    end
    return r;
  endfunction

  // Watch register writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    int i;
    if (!rst_ni) begin
      own_ip_q      = '0;
      own_mac_q     = '0;
      dev_present_q = 1'b0;
      for (i = 0; i < CACHE_ENTRIES; i++) begin
        cache_ip[i]    = '0;
        cache_mac[i]   = '0;
        cache_valid[i] = 1'b0;
      end
      next_victim = 0;
      expected_results.delete();
      mismatch_count_o = 0;
      words_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_IP:  own_ip_q      = cfg_wdata_i[IP_W-1:0];
          CFG_OWN_MAC: own_mac_q     = cfg_wdata_i[MAC_W-1:0];
          CFG_DEV_PRS: dev_present_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %0h with none outstanding", out_word_i));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(out_word_i.status), 64'(want.status));
          check_field("send_frame", 64'(out_word_i.send_frame), 64'(want.send_frame));
          check_field("dest_mac", 64'(out_word_i.dest_mac), 64'(want.dest_mac));
          check_field("tx_operation", 64'(out_word_i.tx_operation),
                      64'(want.tx_operation));
          check_field("tx_target_mac", 64'(out_word_i.tx_target_mac),
                      64'(want.tx_target_mac));
          check_field("tx_target_ip", 64'(out_word_i.tx_target_ip),
                      64'(want.tx_target_ip));
          check_field("resolved_mac", 64'(out_word_i.resolved_mac),
                      64'(want.resolved_mac));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(arp_outcome(in_word_i));
      words_pending_o <= expected_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the ARP cache and responder: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import arpc_pkg::*;

  localparam int                   CLK_HALF    = 2;
  localparam int                   CYCLE_LIMIT = 400000;
  localparam int                   DRAIN_WAIT  = CACHE_ENTRIES + 4;
  localparam int                   POOL_SIZE   = 24;
  localparam int                   HOLD_CYCLES = 300;
  localparam int                   MAX_GAP     = 60;
  localparam int                   PHASE_ITEMS = 112;
  localparam logic [15:0]          OP_REPLY    = 16'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int words_pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycles        = 0;

  logic [IP_W-1:0] ip_pool [POOL_SIZE];
  logic [IP_W-1:0] own_ip_now = '0;

  arp_cache_and_responder_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  arp_cache_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_word_i       (out_word),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .words_pending_o  (words_pending)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Stall the result channel at random, or hold off for a long stretch on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // End the run if it takes far longer than the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] v;
    v[31:0]  = $urandom;
    v[47:32] = 16'($urandom_range(16'hFFFF));
    return v;
  endfunction

  // Mostly addresses that recur, so the cache hits and wraps
  function automatic logic [IP_W-1:0] pick_ip();
    int r;
    r = $urandom_range(99);
    if (r < 15) return own_ip_now;
    if (r < 85) return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Frame with every field random
  function automatic in_word_t noise_frame();
    in_word_t w;
    w.kind        = KIND_FRAME;
    w.payload_len = 16'($urandom);
    w.hw_type     = 16'($urandom);
    w.proto_type  = 16'($urandom);
    w.operation   = 16'($urandom);
    w.sender_mac  = rand_mac();
    w.src_ip      = $urandom;
    w.dst_ip      = $urandom;
    w.query_ip    = $urandom;
    return w;
  endfunction

  function automatic in_word_t good_frame(input logic [15:0] op,
                                          input logic [IP_W-1:0] sip,
                                          input logic [IP_W-1:0] tip);
    in_word_t w;
    w = noise_frame();
    w.payload_len = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF, 28))
                                             : ARP_MIN_LEN;
    w.hw_type    = HTYPE_ETH;
    w.proto_type = PTYPE_IPV4;
    w.operation  = op;
    w.src_ip     = sip;
    w.dst_ip     = tip;
    return w;
  endfunction

  function automatic in_word_t resolve_word(input logic [IP_W-1:0] qip);
    in_word_t w;
    w = noise_frame();
    w.kind     = KIND_RESOLVE;
    w.query_ip = qip;
    return w;
  endfunction

  // Mix of resolves, well-formed frames and broken frames
  function automatic in_word_t random_item();
    in_word_t    w;
    int          r;
    logic [15:0] op;
    r = $urandom_range(99);
    if (r < 40) return resolve_word(pick_ip());
    if (r < 85) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: op = OP_REQ;
        6, 7, 8:          op = OP_REPLY;
        default:          op = 16'($urandom);
      endcase
      return good_frame(op, pick_ip(), ($urandom_range(1) == 1) ? own_ip_now : pick_ip());
    end
    w = good_frame(OP_REQ, pick_ip(), own_ip_now);
    if (r < 91)
      w.payload_len = 16'($urandom_range(ARP_MIN_LEN - 1));
    else if (r < 95)
      w.hw_type = 16'($urandom);
    else if (r < 98)
      w.proto_type = 16'($urandom);
    else
      w = noise_frame();
    return w;
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic push_word(input in_word_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all registers, junk in the unused bits, plus an ignored index
  task automatic set_regs(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                          input logic dev);
    logic [CFG_DATA_W-1:0] junk;
    junk = rand_mac();
    write_reg(CFG_OWN_IP, {junk[47:32], ip});
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_DEV_PRS, {junk[47:1], dev});
    write_reg(CFG_UNUSED, rand_mac());
    cfg_we <= 1'b0;
    own_ip_now = ip;
  endtask

  initial begin
    in_word_t         w;
    logic [IP_W-1:0]  own_a;
    logic [MAC_W-1:0] mac_a;
    int               ph;
    int               sub;
    int               n;

    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    own_a = ip_pool[0];
    mac_a = rand_mac();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: no device, own IP zero
    push_word(resolve_word(ip_pool[1]));
    push_word(good_frame(OP_REQ, '0, '0));
    drain_results();
    set_regs(own_a, mac_a, 1'b1);

    // Short and wrong-type frames
    w = noise_frame();
    w.payload_len = '0;
    push_word(w);
    w = good_frame(OP_REQ, ip_pool[1], own_a);
    w.payload_len = ARP_MIN_LEN - 1;
    push_word(w);
    w = good_frame(OP_REQ, ip_pool[1], own_a);
    w.hw_type = '0;
    push_word(w);
    w.hw_type = 16'hFFFF;
    push_word(w);
    w.hw_type    = HTYPE_ETH;
    w.proto_type = 16'hFFFF;
    push_word(w);

    // Request for us at the largest length, then other operations
    w = good_frame(OP_REQ, ip_pool[1], own_a);
    w.payload_len = 16'hFFFF;
    push_word(w);
    push_word(good_frame(OP_REPLY, ip_pool[2], own_a));
    push_word(good_frame('0, ip_pool[3], own_a));
    push_word(good_frame(16'hFFFF, ip_pool[4], own_a));
    push_word(good_frame(OP_REQ, ip_pool[5], ip_pool[6]));

    // Same sender again updates in place
    push_word(good_frame(OP_REQ, ip_pool[1], own_a));
    w = good_frame(OP_REQ, 32'hFFFF_FFFF, own_a);
    w.sender_mac = BCAST_MAC;
    push_word(w);
    w = good_frame(OP_REPLY, ip_pool[6], 32'hFFFF_FFFF);
    w.sender_mac = '0;
    push_word(w);

    // Hits and misses
    push_word(resolve_word(ip_pool[1]));
    push_word(resolve_word(ip_pool[5]));
    push_word(resolve_word('0));
    push_word(resolve_word(32'hFFFF_FFFF));
    push_word(resolve_word(ip_pool[6]));
    push_word(resolve_word(ip_pool[7]));
    drain_results();

    // Device gone
    set_regs(own_a, mac_a, 1'b0);
    push_word(resolve_word(ip_pool[1]));
    push_word(resolve_word(ip_pool[8]));
    drain_results();

    // Random traffic under each idling pattern and several register settings
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 80; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      for (sub = 0; sub < 3; sub++) begin
        drain_results();
        case (sub)
          0:       set_regs('0, '0, 1'b1);
          1:       set_regs(32'hFFFF_FFFF, BCAST_MAC, 1'b1);
          default: set_regs(ip_pool[$urandom_range(POOL_SIZE - 1)], rand_mac(),
                            ($urandom_range(4) != 0));
        endcase
        for (n = 0; n < PHASE_ITEMS; n++) begin
          // Long hold-off on the result side while items keep coming
          if (ph == 0 && sub == 0 && n == 50) hold_reqs++;
          if (ph == 0 && sub == 0 && n == 62) drain_results();
          push_word(random_item());
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
